FILE: hdl/bzc_pkg.sv
`timescale 1ns / 1ps

package bzc_pkg;

  // fixed field widths
  localparam int ADC_BITS         = 12;
  localparam int NUM_PHASES       = 3;
  localparam int PERIOD_FRAC_BITS = 8;
  localparam int PHASE_W          = 2;
  localparam int STAMP_W          = 32;
  localparam int PERIOD_W         = 24;
  localparam int AMP_W            = 13;
  localparam int BOUND_W          = 16;
  localparam int STREAK_W         = 8;
  localparam int ALPHA_W          = 9;
  localparam int ALPHA_FRAC       = 8;

  // back-emf is 2*x - y - z, three times the phase-to-neutral voltage
  localparam int EMF_W = ADC_BITS + 3;
  localparam int MAG_W = (EMF_W > AMP_W) ? EMF_W : AMP_W;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_AMPLITUDE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_PERIOD    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PERIOD    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCK_COUNT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNLOCK_COUNT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA         = 3'd5;

  localparam logic [AMP_W-1:0]    RST_MIN_AMPLITUDE = 13'd19;
  localparam logic [BOUND_W-1:0]  RST_MIN_PERIOD    = 16'd100;
  localparam logic [BOUND_W-1:0]  RST_MAX_PERIOD    = 16'd50000;
  localparam logic [STREAK_W-1:0] RST_LOCK_COUNT    = 8'd2;
  localparam logic [STREAK_W-1:0] RST_UNLOCK_COUNT  = 8'd5;
  localparam logic [ALPHA_W-1:0]  RST_ALPHA         = 9'd51;

  localparam logic [ALPHA_W-1:0]  ALPHA_MAX  = 9'd256;
  localparam logic [STREAK_W-1:0] STREAK_MAX = '1;

  typedef struct packed {
    logic [AMP_W-1:0]    min_amplitude;
    logic [BOUND_W-1:0]  min_period_us;
    logic [BOUND_W-1:0]  max_period_us;
    logic [STREAK_W-1:0] lock_count;
    logic [STREAK_W-1:0] unlock_count;
    logic [ALPHA_W-1:0]  alpha_q8;
  } cfg_t;

  typedef struct packed {
    logic                restart;
    logic [PHASE_W-1:0]  open_phase;
    logic [ADC_BITS-1:0] phase_a_raw;
    logic [ADC_BITS-1:0] phase_b_raw;
    logic [ADC_BITS-1:0] phase_c_raw;
    logic [STAMP_W-1:0]  timestamp_us;
  } item_t;

  typedef struct packed {
    logic                zero_cross;
    logic                lock_valid;
    logic [PERIOD_W-1:0] period_q8;
    logic [PHASE_W-1:0]  cross_phase;
    logic [STAMP_W-1:0]  last_cross_time_us;
  } result_t;

endpackage

FILE: hdl/bzc_if.sv
`timescale 1ns / 1ps

interface bzc_in_if;
  logic                          valid;
  logic                          ready;
  logic                          restart;
  logic [bzc_pkg::PHASE_W-1:0]   open_phase;
  logic [bzc_pkg::ADC_BITS-1:0]  phase_a_raw;
  logic [bzc_pkg::ADC_BITS-1:0]  phase_b_raw;
  logic [bzc_pkg::ADC_BITS-1:0]  phase_c_raw;
  logic [bzc_pkg::STAMP_W-1:0]   timestamp_us;

  modport source (
    output valid, restart, open_phase, phase_a_raw, phase_b_raw, phase_c_raw,
           timestamp_us,
    input  ready
  );
  modport sink (
    input  valid, restart, open_phase, phase_a_raw, phase_b_raw, phase_c_raw,
           timestamp_us,
    output ready
  );
endinterface

interface bzc_out_if;
  logic                          valid;
  logic                          ready;
  logic                          zero_cross;
  logic                          lock_valid;
  logic [bzc_pkg::PERIOD_W-1:0]  period_q8;
  logic [bzc_pkg::PHASE_W-1:0]   cross_phase;
  logic [bzc_pkg::STAMP_W-1:0]   last_cross_time_us;

  modport source (
    output valid, zero_cross, lock_valid, period_q8, cross_phase, last_cross_time_us,
    input  ready
  );
  modport sink (
    input  valid, zero_cross, lock_valid, period_q8, cross_phase, last_cross_time_us,
    output ready
  );
endinterface

FILE: hdl/bzc_cfg_regs.sv
`timescale 1ns / 1ps

module bzc_cfg_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                we,
  input  logic [bzc_pkg::CFG_IDX_W-1:0]       index,
  input  logic [bzc_pkg::CFG_DATA_W-1:0]      wdata,
  output bzc_pkg::cfg_t                       cfg
);

  bzc_pkg::cfg_t cfg_r;
  bzc_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (we) begin
      case (index)
        bzc_pkg::CFG_MIN_AMPLITUDE: cfg_nxt.min_amplitude = wdata[bzc_pkg::AMP_W-1:0];
        bzc_pkg::CFG_MIN_PERIOD:    cfg_nxt.min_period_us = wdata[bzc_pkg::BOUND_W-1:0];
        bzc_pkg::CFG_MAX_PERIOD:    cfg_nxt.max_period_us = wdata[bzc_pkg::BOUND_W-1:0];
        bzc_pkg::CFG_LOCK_COUNT:    cfg_nxt.lock_count    = wdata[bzc_pkg::STREAK_W-1:0];
        bzc_pkg::CFG_UNLOCK_COUNT:  cfg_nxt.unlock_count  = wdata[bzc_pkg::STREAK_W-1:0];
        bzc_pkg::CFG_ALPHA:         cfg_nxt.alpha_q8      = wdata[bzc_pkg::ALPHA_W-1:0];
        default:                    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_amplitude <= bzc_pkg::RST_MIN_AMPLITUDE;
      cfg_r.min_period_us <= bzc_pkg::RST_MIN_PERIOD;
      cfg_r.max_period_us <= bzc_pkg::RST_MAX_PERIOD;
      cfg_r.lock_count    <= bzc_pkg::RST_LOCK_COUNT;
      cfg_r.unlock_count  <= bzc_pkg::RST_UNLOCK_COUNT;
      cfg_r.alpha_q8      <= bzc_pkg::RST_ALPHA;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: hdl/bzc_period_filter.sv
`timescale 1ns / 1ps

// one-pole filter: old + alpha*(new - old)/256, rounded half up
module bzc_period_filter (
  input  logic [bzc_pkg::PERIOD_W-1:0] old_period,
  input  logic [bzc_pkg::PERIOD_W-1:0] sample,
  input  logic [bzc_pkg::ALPHA_W-1:0]  alpha_q8,
  output logic [bzc_pkg::PERIOD_W-1:0] new_period
);

  localparam int DIFF_W = bzc_pkg::PERIOD_W + 1;
  localparam int PROD_W = DIFF_W + bzc_pkg::ALPHA_W + 1;
  localparam int SUM_W  = PROD_W + 1;

  logic [bzc_pkg::ALPHA_W-1:0] w;
  logic signed [bzc_pkg::ALPHA_W:0] w_s;
  logic signed [DIFF_W-1:0]    diff;
  logic signed [PROD_W-1:0]    prod;
  logic signed [SUM_W-1:0]     base;
  logic signed [SUM_W-1:0]     sum;

  always_comb begin
    w    = (alpha_q8 > bzc_pkg::ALPHA_MAX) ? bzc_pkg::ALPHA_MAX : alpha_q8;
    w_s  = $signed({1'b0, w});
    diff = $signed({1'b0, sample}) - $signed({1'b0, old_period});
    prod = PROD_W'(w_s) * PROD_W'(diff);
    base = $signed(SUM_W'({old_period, {bzc_pkg::ALPHA_FRAC{1'b0}}}));
    sum  = base + SUM_W'(prod) + $signed(SUM_W'(1) <<< (bzc_pkg::ALPHA_FRAC - 1));
    // first valid interval loads the filter directly
    if (old_period == '0) begin
      new_period = sample;
    end else begin
      new_period = sum[bzc_pkg::ALPHA_FRAC +: bzc_pkg::PERIOD_W];
    end
  end

endmodule

FILE: hdl/bzc_track.sv
`timescale 1ns / 1ps

module bzc_track (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             go,
  input  bzc_pkg::item_t   item,
  input  bzc_pkg::cfg_t    cfg,
  output bzc_pkg::result_t result
);

  localparam int PH_IDX_W = $clog2(bzc_pkg::NUM_PHASES);
  localparam int INT_HI_LO = bzc_pkg::PERIOD_W - bzc_pkg::PERIOD_FRAC_BITS;

  logic signed [bzc_pkg::EMF_W-1:0] prev_emf_r [bzc_pkg::NUM_PHASES];
  logic [bzc_pkg::NUM_PHASES-1:0]   boot_r,   boot_nxt;
  logic [bzc_pkg::STAMP_W-1:0]      stamp_r,  stamp_nxt;
  logic [bzc_pkg::PERIOD_W-1:0]     filt_r,   filt_nxt;
  logic [bzc_pkg::STREAK_W-1:0]     good_r,   good_nxt;
  logic [bzc_pkg::STREAK_W-1:0]     bad_r,    bad_nxt;
  logic                             locked_r, locked_nxt;
  logic                             sval_r,   sval_nxt;
  logic [bzc_pkg::PERIOD_W-1:0]     sper_r,   sper_nxt;
  logic [bzc_pkg::PHASE_W-1:0]      sph_r,    sph_nxt;
  logic                             emf_we;

  logic [PH_IDX_W-1:0]              ph;
  logic                             ph_ok;
  logic signed [bzc_pkg::EMF_W-1:0] va, vb, vc, emf, prev;
  logic [bzc_pkg::EMF_W-1:0]        mag_new, mag_prev;
  logic                             quiet, crossed;
  logic [bzc_pkg::STAMP_W-1:0]      interval;
  logic                             in_bounds;
  logic [bzc_pkg::PERIOD_W-1:0]     p_sample, filt_new;
  logic                             zc;

  assign ph    = item.open_phase[PH_IDX_W-1:0];
  assign ph_ok = (item.open_phase < bzc_pkg::PHASE_W'(bzc_pkg::NUM_PHASES));

  always_comb begin
    va = $signed(bzc_pkg::EMF_W'(item.phase_a_raw));
    vb = $signed(bzc_pkg::EMF_W'(item.phase_b_raw));
    vc = $signed(bzc_pkg::EMF_W'(item.phase_c_raw));
    case (item.open_phase)
      2'd0:    emf = (va <<< 1) - vb - vc;
      2'd1:    emf = (vb <<< 1) - va - vc;
      default: emf = (vc <<< 1) - va - vb;
    endcase
    prev     = prev_emf_r[ph];
    mag_new  = emf[bzc_pkg::EMF_W-1]  ? $unsigned(-emf)  : $unsigned(emf);
    mag_prev = prev[bzc_pkg::EMF_W-1] ? $unsigned(-prev) : $unsigned(prev);
    quiet    = (bzc_pkg::MAG_W'(mag_new)  < bzc_pkg::MAG_W'(cfg.min_amplitude)) &&
               (bzc_pkg::MAG_W'(mag_prev) < bzc_pkg::MAG_W'(cfg.min_amplitude));
    crossed  = (emf[bzc_pkg::EMF_W-1] != prev[bzc_pkg::EMF_W-1]) && !quiet;

    interval  = item.timestamp_us - stamp_r;
    in_bounds = !((interval < bzc_pkg::STAMP_W'(cfg.min_period_us)) ||
                  (interval > bzc_pkg::STAMP_W'(cfg.max_period_us)));
    // interval in fixed point, clamped to the period width
    if (|interval[bzc_pkg::STAMP_W-1:INT_HI_LO]) begin
      p_sample = '1;
    end else begin
      p_sample = {interval[INT_HI_LO-1:0], {bzc_pkg::PERIOD_FRAC_BITS{1'b0}}};
    end
  end

  bzc_period_filter u_filter (
    .old_period (filt_r),
    .sample     (p_sample),
    .alpha_q8   (cfg.alpha_q8),
    .new_period (filt_new)
  );

  always_comb begin
    boot_nxt   = boot_r;
    stamp_nxt  = stamp_r;
    filt_nxt   = filt_r;
    good_nxt   = good_r;
    bad_nxt    = bad_r;
    locked_nxt = locked_r;
    sval_nxt   = sval_r;
    sper_nxt   = sper_r;
    sph_nxt    = sph_r;
    emf_we     = 1'b0;
    zc         = 1'b0;

    if (item.restart) begin
      boot_nxt   = '1;
      stamp_nxt  = '0;
      filt_nxt   = '0;
      good_nxt   = '0;
      bad_nxt    = '0;
      locked_nxt = 1'b0;
      sval_nxt   = 1'b0;
      sper_nxt   = '0;
      sph_nxt    = '0;
    end else if (ph_ok) begin
      emf_we = 1'b1;
      if (crossed) begin
        stamp_nxt = item.timestamp_us;
        if (boot_r[ph]) begin
          boot_nxt[ph] = 1'b0;
          sval_nxt     = 1'b0;
        end else if (!in_bounds) begin
          bad_nxt  = (bad_r == bzc_pkg::STREAK_MAX) ? bad_r : bad_r + 1'b1;
          good_nxt = '0;
          if (locked_r && (bad_nxt >= cfg.unlock_count)) begin
            locked_nxt = 1'b0;
          end
          sval_nxt = locked_nxt;
        end else begin
          filt_nxt = filt_new;
          good_nxt = (good_r == bzc_pkg::STREAK_MAX) ? good_r : good_r + 1'b1;
          bad_nxt  = '0;
          if (!locked_r && (good_nxt >= cfg.lock_count)) begin
            locked_nxt = 1'b1;
          end
          sper_nxt = filt_nxt;
          sph_nxt  = item.open_phase;
          sval_nxt = locked_nxt;
          zc       = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < bzc_pkg::NUM_PHASES; i++) begin
        prev_emf_r[i] <= '0;
      end
      boot_r   <= '1;
      stamp_r  <= '0;
      filt_r   <= '0;
      good_r   <= '0;
      bad_r    <= '0;
      locked_r <= 1'b0;
      sval_r   <= 1'b0;
      sper_r   <= '0;
      sph_r    <= '0;
    end else if (go) begin
      if (item.restart) begin
        for (int i = 0; i < bzc_pkg::NUM_PHASES; i++) begin
          prev_emf_r[i] <= '0;
        end
      end else if (emf_we) begin
        prev_emf_r[ph] <= emf;
      end
      boot_r   <= boot_nxt;
      stamp_r  <= stamp_nxt;
      filt_r   <= filt_nxt;
      good_r   <= good_nxt;
      bad_r    <= bad_nxt;
      locked_r <= locked_nxt;
      sval_r   <= sval_nxt;
      sper_r   <= sper_nxt;
      sph_r    <= sph_nxt;
    end
  end

  always_comb begin
    result.zero_cross         = zc;
    result.lock_valid         = sval_nxt;
    result.period_q8          = sper_nxt;
    result.cross_phase        = sph_nxt;
    result.last_cross_time_us = stamp_nxt;
  end

endmodule

FILE: hdl/bemf_zero_cross_detector.sv
`timescale 1ns / 1ps
// an accepted word moves from the input register to the result register when that is empty or being drained
// throughput: one word per cycle while the result channel is not stalled; the whole
//   tracking update is combinational between the input register and the result register
// reset (rst_n low, synchronous): tracking state cleared, bootstrap armed on all
//   three phases, configuration back to defaults, both stages emptied

module bemf_zero_cross_detector (
  input  logic                            clk,
  input  logic                            rst_n,
  bzc_in_if.sink                          in_ch,
  bzc_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [bzc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bzc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  bzc_pkg::cfg_t    cfg;
  bzc_pkg::item_t   in_word;
  bzc_pkg::result_t trk_result;

  // input register stage
  logic             s1_valid_r, s1_valid_nxt;
  bzc_pkg::item_t   s1_item_r;
  // result register stage
  logic             out_valid_r, out_valid_nxt;
  bzc_pkg::result_t out_res_r;

  logic             in_take;
  logic             s1_go;

  bzc_cfg_regs u_cfg (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (cfg_we),
    .index (cfg_index),
    .wdata (cfg_wdata),
    .cfg   (cfg)
  );

  // state is only touched when the staged word moves into the result register
  bzc_track u_track (
    .clk    (clk),
    .rst_n  (rst_n),
    .go     (s1_go),
    .item   (s1_item_r),
    .cfg    (cfg),
    .result (trk_result)
  );

  always_comb begin
    in_word.restart      = in_ch.restart;
    in_word.open_phase   = in_ch.open_phase;
    in_word.phase_a_raw  = in_ch.phase_a_raw;
    in_word.phase_b_raw  = in_ch.phase_b_raw;
    in_word.phase_c_raw  = in_ch.phase_c_raw;
    in_word.timestamp_us = in_ch.timestamp_us;
  end

  // staged word advances when the result register is empty or being drained
  assign s1_go       = s1_valid_r && (!out_valid_r || out_ch.ready);
  // the input stage frees up as its word advances, so a word can enter each cycle
  assign in_ch.ready = !s1_valid_r || s1_go;
  assign in_take     = in_ch.valid && in_ch.ready;

  always_comb begin
    s1_valid_nxt = in_take ? 1'b1 : (s1_go ? 1'b0 : s1_valid_r);
    if (s1_go) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r <= in_word;
    end
    if (s1_go) begin
      out_res_r <= trk_result;
    end
  end

  assign out_ch.valid              = out_valid_r;
  assign out_ch.zero_cross         = out_res_r.zero_cross;
  assign out_ch.lock_valid         = out_res_r.lock_valid;
  assign out_ch.period_q8          = out_res_r.period_q8;
  assign out_ch.cross_phase        = out_res_r.cross_phase;
  assign out_ch.last_cross_time_us = out_res_r.last_cross_time_us;

endmodule
